// ----- hdl/fwwt_pkg.sv -----
package fwwt_pkg;

	localparam int FutexSlots = 16;
	localparam int WaitersPerFutex = 8;
	localparam int AddressBits = 48;
	localparam int ThreadIdBits = 16;
	localparam int EntryBits = $clog2(FutexSlots);
	localparam int SlotBits = (WaitersPerFutex > 1) ? $clog2(WaitersPerFutex) : 1;
	localparam int WaiterTotal = FutexSlots * WaitersPerFutex;
	localparam int WaiterBits = $clog2(WaiterTotal);
	localparam int CountBits = 4;

	localparam logic [2:0] ST_QUEUED = 3'd0;
	localparam logic [2:0] ST_VALUE_CHANGED = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_WAKE = 3'd4;

	typedef struct packed {
		logic                    req_type;
		logic [AddressBits-1:0]  address;
		logic [ThreadIdBits-1:0] thread_id;
		logic [63:0]             current_value;
		logic [63:0]             expected_value;
	} req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic                    woken_valid;
		logic [ThreadIdBits-1:0] woken_thread;
		logic [CountBits-1:0]    wake_count;
		logic                    last;
	} res_t;

	// Classified command handed from the front part to the back part.
	typedef struct packed {
		logic                    is_wake;
		logic                    mismatch;
		logic [AddressBits-1:0]  address;
		logic [ThreadIdBits-1:0] thread_id;
	} cmd_t;

endpackage

// ----- hdl/futex_wait_wake_table.sv -----
// Futex wait/wake table: 16 futex entries with 8 waiter slots each, queue-style
// ports on both sides. A request passes the command queue, is captured in S_IDLE
// and classified in S_LOOK; a value change, a full table or a wake that finds no
// waiter then gives its result through S_OUT. A wait that queues or finds the queue
// full first scans the waiter slots in S_SLOT, one per cycle, up to the free one. A
// wake scans one waiter slot per cycle, holding on an occupied slot until the output
// register is free, and gives one result per occupied slot, in slot order, with the
// count on the last one. A waiting result stalls the engine, and a two-deep command
// queue keeps taking requests meanwhile.
module futex_wait_wake_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  fwwt_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output fwwt_pkg::res_t res
);
	import fwwt_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	fwwt_front u_front (
		.clk, .arst_n, .push, .full, .req, .cmd_valid, .cmd_ready, .cmd
	);

	fwwt_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .empty, .pop, .res
	);

	// A wait result is always a single final transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.status != ST_WAKE) |-> res.last)
		else $error("wait result without last");

	// A released thread is only reported by a wake result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.woken_valid) |-> (res.status == ST_WAKE))
		else $error("woken thread on non-wake result");

	// A waiting result holds while it is not popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res)))
		else $error("result changed before transfer");

endmodule

// ----- hdl/fwwt_front.sv -----
module fwwt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  fwwt_pkg::req_t  req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output fwwt_pkg::cmd_t  cmd
);
	import fwwt_pkg::*;

	// Two-entry command queue between the classifier and the table engine.
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push, do_pop;

	// Classify: the value compare only matters for waits.
	always_comb begin
		cls.is_wake   = req.req_type;
		cls.mismatch  = !req.req_type && (req.current_value != req.expected_value);
		cls.address   = req.address;
		cls.thread_id = req.thread_id;
	end

	assign full      = (cnt_q == 2'd2);
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_pop    = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- hdl/fwwt_back.sv -----
module fwwt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  fwwt_pkg::cmd_t  cmd,
	output logic            empty,
	input  logic            pop,
	output fwwt_pkg::res_t  res
);
	import fwwt_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SLOT, S_WAKE, S_OUT} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [FutexSlots-1:0]   entry_used_q;
	logic [AddressBits-1:0]  entry_address_q [FutexSlots];
	logic [WaiterTotal-1:0]  waiter_used_q;
	logic [ThreadIdBits-1:0] waiter_thread_q [WaiterTotal];
	logic [EntryBits-1:0]    ent_q;
	logic [SlotBits-1:0]     slot_q;
	logic [CountBits-1:0]    cnt_q;
	logic [2:0]              st_q;
	res_t                    res_q;
	logic                    res_full_q;

	logic [FutexSlots-1:0]      match;
	logic                       any_match, any_free;
	logic [EntryBits-1:0]       match_idx, free_idx;
	logic [WaiterBits-1:0]      widx;
	logic                       more;
	logic [WaitersPerFutex-1:0] hit_slots, cur_slots, later;
	logic                       last_wake;
	logic                       out_free;
	logic                       emit;
	logic                       thr_we;
	res_t                       wake_res, single_res;

	// Address compare against every entry, and priority picks.
	always_comb begin
		any_match = 1'b0;
		any_free  = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int i = FutexSlots - 1; i >= 0; i--) begin
			match[i] = entry_used_q[i] && (entry_address_q[i] == cmd_q.address);
			if (match[i]) begin
				any_match = 1'b1;
				match_idx = EntryBits'(i);
			end
			if (!entry_used_q[i]) begin
				any_free = 1'b1;
				free_idx = EntryBits'(i);
			end
		end
	end

	// Waiter slot index of the current entry and slot.
	assign widx = WaiterBits'({ent_q, slot_q[SlotBits-1:0]} & {WaiterBits{1'b1}});
	assign more = (32'(slot_q) != WaitersPerFutex - 1);

	// Occupied slots of the matched and of the current entry.
	assign hit_slots = waiter_used_q[int'(match_idx) * WaitersPerFutex +: WaitersPerFutex];
	assign cur_slots = waiter_used_q[int'(ent_q) * WaitersPerFutex +: WaitersPerFutex];

	// A wake result is the last one when no occupied slot follows it.
	always_comb begin
		for (int w = 0; w < WaitersPerFutex; w++) begin
			later[w] = cur_slots[w] && (w > int'(slot_q));
		end
	end
	assign last_wake = (later == '0);

	// Result words for a released thread and for a single final result.
	always_comb begin
		wake_res.status       = ST_WAKE;
		wake_res.woken_valid  = 1'b1;
		wake_res.woken_thread = waiter_thread_q[widx];
		wake_res.wake_count   = last_wake ? cnt_q + 1'b1 : '0;
		wake_res.last         = last_wake;
		single_res.status       = st_q;
		single_res.woken_valid  = 1'b0;
		single_res.woken_thread = '0;
		single_res.wake_count   = '0;
		single_res.last         = 1'b1;
	end

	assign out_free  = !res_full_q || pop;
	assign emit      = out_free && (((state_q == S_WAKE) && waiter_used_q[widx]) ||
		(state_q == S_OUT));
	assign thr_we    = (state_q == S_SLOT) && !waiter_used_q[widx];
	assign cmd_ready = (state_q == S_IDLE);
	assign empty     = !res_full_q;
	assign res       = res_q;

	// Thread ids of the waiter slots; a slot is only read while it is occupied.
	always_ff @(posedge clk) begin
		if (thr_we) begin
			waiter_thread_q[widx] <= cmd_q.thread_id;
		end
	end

	// Table engine sequencer; each result waits in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_used_q  <= '0;
			waiter_used_q <= '0;
			res_full_q    <= 1'b0;
			for (int i = 0; i < FutexSlots; i++) entry_address_q[i] <= '0;
			cmd_q  <= '0;
			ent_q  <= '0;
			slot_q <= '0;
			cnt_q  <= '0;
			st_q   <= ST_QUEUED;
			res_q  <= '0;
		end else begin
			if (emit) begin
				res_full_q <= 1'b1;
			end else if (pop) begin
				res_full_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					slot_q <= '0;
					cnt_q  <= '0;
					if (cmd_q.is_wake) begin
						ent_q <= match_idx;
						st_q  <= ST_WAKE;
						state_q <= (any_match && hit_slots != '0) ? S_WAKE : S_OUT;
					end else if (cmd_q.mismatch) begin
						st_q    <= ST_VALUE_CHANGED;
						state_q <= S_OUT;
					end else if (any_match) begin
						ent_q   <= match_idx;
						state_q <= S_SLOT;
					end else if (any_free) begin
						ent_q <= free_idx;
						entry_used_q[free_idx]    <= 1'b1;
						entry_address_q[free_idx] <= cmd_q.address;
						state_q <= S_SLOT;
					end else begin
						st_q    <= ST_TABLE_FULL;
						state_q <= S_OUT;
					end
				end
				// Wait: scan waiter slots one per cycle for the first free one.
				S_SLOT: begin
					if (!waiter_used_q[widx]) begin
						waiter_used_q[widx] <= 1'b1;
						st_q    <= ST_QUEUED;
						state_q <= S_OUT;
					end else if (more) begin
						slot_q <= slot_q + 1'b1;
					end else begin
						st_q    <= ST_QUEUE_FULL;
						state_q <= S_OUT;
					end
				end
				// Wake: release used slots in order, one result per transfer.
				S_WAKE: begin
					if (waiter_used_q[widx]) begin
						if (out_free) begin
							waiter_used_q[widx] <= 1'b0;
							cnt_q <= cnt_q + 1'b1;
							res_q <= wake_res;
							if (last_wake) begin
								state_q <= S_IDLE;
							end else begin
								slot_q <= slot_q + 1'b1;
							end
						end
					end else if (last_wake) begin
						state_q <= S_IDLE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				// Finish: emit the single result of a wait or an empty wake.
				S_OUT: begin
					if (out_free) begin
						res_q   <= single_res;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import fwwt_pkg::*;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t req;
	logic empty;
	logic pop;
	res_t res;

	futex_wait_wake_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	// Predicted table contents.
	logic                    tbl_used [FutexSlots];
	logic [AddressBits-1:0]  tbl_addr [FutexSlots];
	logic                    slot_used [WaiterTotal];
	logic [ThreadIdBits-1:0] slot_tid [WaiterTotal];

	req_t pending_reqs[$];
	res_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 27;
	int recv_idle_pct = 50;
	int hold_cycles = 0;
	longint cycles = 0;

	// Known addresses so that waits and wakes meet on the same futexes.
	logic [AddressBits-1:0] addr_pool[$];

	always #5 clk = ~clk;

	function automatic res_t mk_res(logic [2:0] st, logic v, logic [ThreadIdBits-1:0] t,
			logic [CountBits-1:0] c, logic l);
		res_t r;
		r.status = st;
		r.woken_valid = v;
		r.woken_thread = t;
		r.wake_count = c;
		r.last = l;
		return r;
	endfunction

	// Apply one accepted request to the predicted table and queue its results.
	function automatic void predict_futex(req_t r);
		int e;
		int n;
		logic [2:0] st;
		e = -1;
		n = 0;
		for (int i = 0; i < FutexSlots; i++)
			if (e < 0 && tbl_used[i] && tbl_addr[i] == r.address)
				e = i;
		if (!r.req_type) begin
			if (r.current_value != r.expected_value) begin
				st = ST_VALUE_CHANGED;
			end else begin
				if (e < 0) begin
					for (int i = 0; i < FutexSlots; i++)
						if (e < 0 && !tbl_used[i])
							e = i;
					if (e >= 0) begin
						tbl_used[e] = 1;
						tbl_addr[e] = r.address;
					end
				end
				if (e < 0) begin
					st = ST_TABLE_FULL;
				end else begin
					st = ST_QUEUE_FULL;
					for (int w = 0; w < WaitersPerFutex; w++)
						if (st == ST_QUEUE_FULL && !slot_used[e*WaitersPerFutex+w]) begin
							slot_used[e*WaitersPerFutex+w] = 1;
							slot_tid[e*WaitersPerFutex+w] = r.thread_id;
							st = ST_QUEUED;
						end
				end
			end
			expected_results.push_back(mk_res(st, 0, '0, '0, 1));
			return;
		end
		if (e >= 0) begin
			for (int w = 0; w < WaitersPerFutex; w++) begin
				if (slot_used[e*WaitersPerFutex+w]) begin
					expected_results.push_back(mk_res(ST_WAKE, 1,
						slot_tid[e*WaitersPerFutex+w], '0, 0));
					slot_used[e*WaitersPerFutex+w] = 0;
					slot_tid[e*WaitersPerFutex+w] = '0;
					n++;
				end
			end
		end
		if (n == 0) begin
			expected_results.push_back(mk_res(ST_WAKE, 0, '0, '0, 1));
		end else begin
			expected_results[$].wake_count = CountBits'(n);
			expected_results[$].last = 1;
		end
	endfunction

	function automatic req_t mk_req(logic wake, logic [AddressBits-1:0] a,
			logic [ThreadIdBits-1:0] t, logic [63:0] cur, logic [63:0] exp_v);
		req_t r;
		r.req_type = wake;
		r.address = a;
		r.thread_id = t;
		r.current_value = cur;
		r.expected_value = exp_v;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic req_t random_req();
		logic [63:0] v;
		logic [AddressBits-1:0] a;
		int k;
		k = $urandom_range(0, 99);
		if (k < 3)
			a = AddressBits'(rand64());
		else
			a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
		v = rand64();
		if (k < 60)
			return mk_req(0, a, ThreadIdBits'($urandom()), v, v);
		else if (k < 70)
			return mk_req(0, a, ThreadIdBits'($urandom()), v, rand64());
		else
			return mk_req(1, a, ThreadIdBits'($urandom()), v, rand64());
	endfunction

	// Driver: offers items from the pending queue, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			req <= '0;
		end else begin
			if (push && !full) begin
				predict_futex(req);
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > (push && !full ? 1 : 0) ||
					(!(push && !full) && pending_reqs.size() > 0)) begin
				if ($urandom_range(0, 99) < send_idle_pct && !(push && full)) begin
					push <= 0;
				end else begin
					push <= 1;
					req <= pending_reqs[0];
				end
			end else begin
				push <= 0;
			end
		end
	end

	// Monitor: takes results, checks them against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
		end else begin
			cycles <= cycles + 1;
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, res);
					errors++;
				end else begin
					if (res !== expected_results[0]) begin
						$display("%0t: mismatch expected %p actual %p", $time,
							expected_results[0], res);
						errors++;
					end
					void'(expected_results.pop_front());
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Ends the run when the cycle limit runs out.
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || push || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		push = 0;
		pop = 0;
		req = '0;
		for (int i = 0; i < FutexSlots; i++) begin
			tbl_used[i] = 0;
			tbl_addr[i] = '0;
		end
		for (int i = 0; i < WaiterTotal; i++) begin
			slot_used[i] = 0;
			slot_tid[i] = '0;
		end
		addr_pool.push_back(1);
		addr_pool.push_back({AddressBits{1'b1}});
		for (int i = 0; i < 12; i++)
			addr_pool.push_back(AddressBits'(rand64()));
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, value change, queue full, duplicates, id zero, empty wakes.
		pending_reqs.push_back(mk_req(1, 1, 1, 0, 0));
		pending_reqs.push_back(mk_req(0, 1, 0, '1, '1));
		pending_reqs.push_back(mk_req(0, 1, '1, 0, 0));
		pending_reqs.push_back(mk_req(0, 1, '1, 0, 0));
		pending_reqs.push_back(mk_req(0, 1, 5, 0, '1));
		pending_reqs.push_back(mk_req(0, 1, 5, '1, 0));
		for (int i = 0; i < 6; i++)
			pending_reqs.push_back(mk_req(0, 1, ThreadIdBits'(i + 10), 64'h5a5a, 64'h5a5a));
		pending_reqs.push_back(mk_req(1, 1, 0, 0, 0));
		pending_reqs.push_back(mk_req(1, 1, 0, 0, 0));
		pending_reqs.push_back(mk_req(0, {AddressBits{1'b1}}, 7, '1, '1));
		pending_reqs.push_back(mk_req(1, {AddressBits{1'b1}}, 7, '1, '1));
		pending_reqs.push_back(mk_req(1, 48'h5555_5555_5555, 7, 1, 2));
		// Fill the table with distinct addresses until it reports full.
		for (int i = 0; i < FutexSlots + 1; i++)
			pending_reqs.push_back(mk_req(0, AddressBits'(48'h100 + i), 3, 9, 9));
		wait_drained();

		// Fresh state is impossible without reset, so pool reuses allocated entries.
		for (int i = 0; i < FutexSlots - 3; i++)
			addr_pool.push_back(AddressBits'(48'h100 + i));
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 27 : phase == 1 ? 50 : 0;
			recv_idle_pct = phase == 0 ? 50 : phase == 1 ? 27 : 0;
			if (phase == 2)
				hold_cycles = 300;
			for (int i = 0; i < 117; i++)
				pending_reqs.push_back(random_req());
			wait_drained();
		end
		// Flush remaining waiters so wake bursts appear at the end too.
		for (int i = 0; i < addr_pool.size(); i++)
			pending_reqs.push_back(mk_req(1, addr_pool[i], 0, 0, 0));
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
